@@ rtl/trr_pkg.sv @@
// shared widths and types for the triangle radius ratio quality pipeline
`timescale 1ns / 1ps
`default_nettype none
package trr_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SQ_W      = PROD_W;
    localparam int LEN_W     = SQ_W / 2;
    localparam int NUM_W     = LEN_W + 1;
    localparam int SNUM_W    = LEN_W + 2;
    localparam int INT_FRAC  = 30;
    localparam int RATIO_W   = INT_FRAC + 2;
    localparam int DIV_STEPS = RATIO_W;
    localparam int QFRAC     = 16;
    localparam int Q_W       = QFRAC + 1;
    localparam int P1_W      = 2 * RATIO_W - INT_FRAC;
    localparam int P2_W      = P1_W + RATIO_W - INT_FRAC;
    localparam int SQRT_LAT  = LEN_W;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    typedef struct packed {
        logic valid;
        logic zero;
        logic col;
    } front_flags_t;

    typedef struct packed {
        logic valid;
        logic zero;
        logic kill;
    } back_flags_t;

endpackage
`default_nettype wire

@@ rtl/trr_sqrt.sv @@
// pipelined floor square root, one result digit per stage
`timescale 1ns / 1ps
`default_nettype none
module trr_sqrt
    import trr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [SQ_W-1:0]  radicand,
    output logic      [LEN_W-1:0] root
);

    localparam int REM_W = LEN_W + 2;

    logic [SQ_W-1:0]  rad_q  [0:LEN_W-1];
    logic [REM_W-1:0] rem_q  [0:LEN_W-1];
    logic [LEN_W-1:0] root_q [0:LEN_W-1];

    for (genvar k = 0; k < LEN_W; k++) begin : g_stage
        logic [SQ_W-1:0]  rad_in;
        logic [REM_W-1:0] rem_in;
        logic [LEN_W-1:0] root_in;
        logic [REM_W+1:0] remx;
        logic [REM_W+1:0] trial;
        logic             take;

        if (k == 0) begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_next
            assign rad_in  = rad_q[k-1];
            assign rem_in  = rem_q[k-1];
            assign root_in = root_q[k-1];
        end

        assign remx  = {rem_in, rad_in[SQ_W-1 -: 2]};
        assign trial = {{(REM_W-LEN_W){1'b0}}, root_in, 2'b01};
        assign take  = remx >= trial;

        always_ff @(posedge clk)
        begin
            rad_q[k]  <= rad_in << 2;
            rem_q[k]  <= take ? REM_W'(remx - trial) : REM_W'(remx);
            root_q[k] <= {root_in[LEN_W-2:0], take};
        end
    end

    assign root = root_q[LEN_W-1];

endmodule
`default_nettype wire

@@ rtl/trr_div.sv @@
// pipelined restoring divider giving (num << 30) / den saturated to 2.0
`timescale 1ns / 1ps
`default_nettype none
module trr_div
    import trr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [LEN_W-1:0]   den,
    output logic      [RATIO_W-1:0] ratio
);

    localparam logic [RATIO_W-1:0] TWO = RATIO_W'(2) << INT_FRAC;

    logic [LEN_W-1:0]   rem_q [0:DIV_STEPS];
    logic [RATIO_W-1:0] low_q [0:DIV_STEPS];
    logic [RATIO_W-1:0] quo_q [0:DIV_STEPS];
    logic [LEN_W-1:0]   den_q [0:DIV_STEPS];
    logic               sat_q [0:DIV_STEPS];
    logic [RATIO_W-1:0] ratio_reg;

    // quotient of four or more cannot fit the 32 result bits
    always_ff @(posedge clk)
    begin
        sat_q[0] <= {1'b0, num} >= {den, 2'b00};
        rem_q[0] <= LEN_W'(num >> 2);
        low_q[0] <= {num[1:0], {(RATIO_W-2){1'b0}}};
        quo_q[0] <= '0;
        den_q[0] <= den;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [LEN_W:0] remx;
        logic           ge;

        assign remx = {rem_q[k-1], low_q[k-1][RATIO_W-1]};
        assign ge   = remx >= {1'b0, den_q[k-1]};

        always_ff @(posedge clk)
        begin
            rem_q[k] <= ge ? LEN_W'(remx - {1'b0, den_q[k-1]}) : LEN_W'(remx);
            low_q[k] <= low_q[k-1] << 1;
            quo_q[k] <= {quo_q[k-1][RATIO_W-2:0], ge};
            den_q[k] <= den_q[k-1];
            sat_q[k] <= sat_q[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sat_q[DIV_STEPS] || quo_q[DIV_STEPS] > TWO)
            ratio_reg <= TWO;
        else
            ratio_reg <= quo_q[DIV_STEPS];
    end

    assign ratio = ratio_reg;

endmodule
`default_nettype wire

@@ rtl/triangle_radius_ratio_quality.sv @@
// top level of the triangle radius ratio quality pipeline
// throughput: one triangle per cycle; busy stays low, the pipeline never stalls
// the depth is set by the 33-stage square root and the 34-stage dividers
// reset clears the valid and flag registers only; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module triangle_radius_ratio_quality
    import trr_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [COORD_W-1:0] vertex0_x,
    input  wire logic signed [COORD_W-1:0] vertex0_y,
    input  wire logic signed [COORD_W-1:0] vertex0_z,
    input  wire logic signed [COORD_W-1:0] vertex1_x,
    input  wire logic signed [COORD_W-1:0] vertex1_y,
    input  wire logic signed [COORD_W-1:0] vertex1_z,
    input  wire logic signed [COORD_W-1:0] vertex2_x,
    input  wire logic signed [COORD_W-1:0] vertex2_y,
    input  wire logic signed [COORD_W-1:0] vertex2_z,
    output logic                           done,
    output logic             [Q_W-1:0]     quality_ratio,
    output logic                           degenerate
);

    localparam logic [P2_W-1:0] ONE_INT = P2_W'(1) << INT_FRAC;
    localparam logic [Q_W-1:0]  Q_ONE   = Q_W'(1) << QFRAC;

    // stage 1: edge vectors
    logic signed [DIFF_W-1:0] e1_reg [0:2];
    logic signed [DIFF_W-1:0] e2_reg [0:2];
    logic signed [DIFF_W-1:0] e3_reg [0:2];
    logic                     v1_reg;

    // stage 2: squares and cross product terms
    logic signed [PROD_W-1:0] s1_reg [0:2];
    logic signed [PROD_W-1:0] s2_reg [0:2];
    logic signed [PROD_W-1:0] s3_reg [0:2];
    logic signed [PROD_W-1:0] cr_reg [0:5];
    logic                     v2_reg;

    // stage 3: squared lengths and flags
    logic [SQ_W-1:0] la2_reg, lb2_reg, lc2_reg;
    front_flags_t    f3_reg;
    logic [SQ_W-1:0] la2_next, lb2_next, lc2_next;

    front_flags_t    fa_reg [0:SQRT_LAT-1];
    logic [LEN_W-1:0] la, lb, lc;

    // stage 4: numerators
    logic [NUM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic [LEN_W-1:0] da_reg, db_reg, dc_reg;
    back_flags_t      f4_reg;
    logic signed [SNUM_W-1:0] x_next, y_next, z_next;
    logic             bad;

    back_flags_t      fb_reg [0:DIV_LAT-1];
    logic [RATIO_W-1:0] rx, ry, rz;

    // stages 5 to 7: products and output
    logic [P1_W-1:0]    p1_reg;
    logic [RATIO_W-1:0] rz_reg;
    back_flags_t        f5_reg;
    logic [2*RATIO_W-1:0] p1_next;
    logic [P2_W-1:0]    p2_reg;
    back_flags_t        f6_reg;
    logic [P1_W+RATIO_W-1:0] p2_next;
    logic [P2_W-1:0]    qc;

    logic               done_reg;
    logic [Q_W-1:0]     quality_reg;
    logic               degenerate_reg;

    always_ff @(posedge clk)
    begin
        e1_reg[0] <= DIFF_W'(vertex1_x) - DIFF_W'(vertex0_x);
        e1_reg[1] <= DIFF_W'(vertex1_y) - DIFF_W'(vertex0_y);
        e1_reg[2] <= DIFF_W'(vertex1_z) - DIFF_W'(vertex0_z);
        e2_reg[0] <= DIFF_W'(vertex2_x) - DIFF_W'(vertex1_x);
        e2_reg[1] <= DIFF_W'(vertex2_y) - DIFF_W'(vertex1_y);
        e2_reg[2] <= DIFF_W'(vertex2_z) - DIFF_W'(vertex1_z);
        e3_reg[0] <= DIFF_W'(vertex0_x) - DIFF_W'(vertex2_x);
        e3_reg[1] <= DIFF_W'(vertex0_y) - DIFF_W'(vertex2_y);
        e3_reg[2] <= DIFF_W'(vertex0_z) - DIFF_W'(vertex2_z);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_reg[i] <= e1_reg[i] * e1_reg[i];
            s2_reg[i] <= e2_reg[i] * e2_reg[i];
            s3_reg[i] <= e3_reg[i] * e3_reg[i];
        end
        cr_reg[0] <= e1_reg[1] * e3_reg[2];
        cr_reg[1] <= e1_reg[2] * e3_reg[1];
        cr_reg[2] <= e1_reg[2] * e3_reg[0];
        cr_reg[3] <= e1_reg[0] * e3_reg[2];
        cr_reg[4] <= e1_reg[0] * e3_reg[1];
        cr_reg[5] <= e1_reg[1] * e3_reg[0];
    end

    // squares are below 2^64, so their sum fits unsigned
    assign la2_next = SQ_W'(s1_reg[0]) + SQ_W'(s1_reg[1]) + SQ_W'(s1_reg[2]);
    assign lb2_next = SQ_W'(s2_reg[0]) + SQ_W'(s2_reg[1]) + SQ_W'(s2_reg[2]);
    assign lc2_next = SQ_W'(s3_reg[0]) + SQ_W'(s3_reg[1]) + SQ_W'(s3_reg[2]);

    always_ff @(posedge clk)
    begin
        la2_reg <= la2_next;
        lb2_reg <= lb2_next;
        lc2_reg <= lc2_next;
    end

    trr_sqrt u_sqrt_a (.clk(clk), .radicand(la2_reg), .root(la));
    trr_sqrt u_sqrt_b (.clk(clk), .radicand(lb2_reg), .root(lb));
    trr_sqrt u_sqrt_c (.clk(clk), .radicand(lc2_reg), .root(lc));

    assign x_next = SNUM_W'(lb) + SNUM_W'(lc) - SNUM_W'(la);
    assign y_next = SNUM_W'(la) + SNUM_W'(lc) - SNUM_W'(lb);
    assign z_next = SNUM_W'(la) + SNUM_W'(lb) - SNUM_W'(lc);
    // triangle inequality broken by rounding, or an empty side
    assign bad = (x_next <= 0) || (y_next <= 0) || (z_next <= 0)
              || (la == '0) || (lb == '0) || (lc == '0);

    always_ff @(posedge clk)
    begin
        nx_reg <= NUM_W'(x_next);
        ny_reg <= NUM_W'(y_next);
        nz_reg <= NUM_W'(z_next);
        da_reg <= la;
        db_reg <= lb;
        dc_reg <= lc;
    end

    trr_div u_div_x (.clk(clk), .num(nx_reg), .den(db_reg), .ratio(rx));
    trr_div u_div_y (.clk(clk), .num(ny_reg), .den(dc_reg), .ratio(ry));
    trr_div u_div_z (.clk(clk), .num(nz_reg), .den(da_reg), .ratio(rz));

    assign p1_next = rx * ry;
    assign p2_next = p1_reg * rz_reg;
    assign qc      = (p2_reg > ONE_INT) ? ONE_INT : p2_reg;

    always_ff @(posedge clk)
    begin
        p1_reg      <= p1_next[2*RATIO_W-1:INT_FRAC];
        rz_reg      <= rz;
        p2_reg      <= p2_next[P1_W+RATIO_W-1:INT_FRAC];
        quality_reg <= f6_reg.kill ? '0 : qc[INT_FRAC:INT_FRAC-QFRAC];
        degenerate_reg <= f6_reg.zero;
    end

    // valid and flag line travelling alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            f3_reg   <= '0;
            f4_reg   <= '0;
            f5_reg   <= '0;
            f6_reg   <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < SQRT_LAT; i++)
            begin
                fa_reg[i] <= '0;
            end
            for (int i = 0; i < DIV_LAT; i++)
            begin
                fb_reg[i] <= '0;
            end
        end
        else
        begin
            v1_reg       <= start;
            v2_reg       <= v1_reg;
            f3_reg.valid <= v2_reg;
            f3_reg.zero  <= (la2_next == '0) || (lb2_next == '0) || (lc2_next == '0);
            f3_reg.col   <= (cr_reg[0] == cr_reg[1]) && (cr_reg[2] == cr_reg[3])
                         && (cr_reg[4] == cr_reg[5]);
            fa_reg[0]    <= f3_reg;
            for (int i = 1; i < SQRT_LAT; i++)
            begin
                fa_reg[i] <= fa_reg[i-1];
            end
            f4_reg.valid <= fa_reg[SQRT_LAT-1].valid;
            f4_reg.zero  <= fa_reg[SQRT_LAT-1].zero;
            f4_reg.kill  <= fa_reg[SQRT_LAT-1].zero || fa_reg[SQRT_LAT-1].col || bad;
            fb_reg[0]    <= f4_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                fb_reg[i] <= fb_reg[i-1];
            end
            f5_reg   <= fb_reg[DIV_LAT-1];
            f6_reg   <= f5_reg;
            done_reg <= f6_reg.valid;
        end
    end

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign quality_ratio = quality_reg;
    assign degenerate    = degenerate_reg;

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> quality_ratio == '0)
        else $error("degenerate triangle with nonzero quality");

    a_quality_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> quality_ratio <= Q_ONE)
        else $error("quality above one");

    a_kill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        f6_reg.valid && f6_reg.kill |=> quality_ratio == '0)
        else $error("rejected triangle gave nonzero quality");
`endif

endmodule
`default_nettype wire
